/* design/assert_macros.svh */
// assertion macros shared by the span record sorter
// clocked on clock, disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising edge outside reset
`define SRS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication checked from one edge to the next
`define SRS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

/* design/srs_pkg.sv */
// package for the span record sorter: sizes, word types, sequencer states
// no dependencies
package srs_pkg;

   localparam int MAX_RECORDS = 64;
   localparam int POS_WIDTH   = 24;
   localparam int IDX_W       = 6;
   localparam int CNT_W       = 7;

   typedef struct packed {
      logic [POS_WIDTH-1:0] left_pos;
      logic [POS_WIDTH-1:0] right_pos;
      logic                 final_record;
   } req_word_type;

   typedef struct packed {
      logic [IDX_W-1:0]     record_number;
      logic [POS_WIDTH-1:0] out_left;
      logic [POS_WIDTH-1:0] out_right;
      logic                 out_last;
      logic                 dropped;
   } rsp_word_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0] left;
      logic [POS_WIDTH-1:0] right;
      logic [IDX_W-1:0]     order;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } store_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_CHECK,
      ST_FETCH,
      ST_LOAD,
      ST_SEND
   } state_type;

endpackage

/* design/srs_store.sv */
// record store: one write port, one read port with registered read data
// depends on srs_pkg
module srs_store (
   input  logic                  clock,
   input  srs_pkg::store_ctl_type ctl,
   output srs_pkg::entry_type    rd_data
);

   srs_pkg::entry_type mem [srs_pkg::MAX_RECORDS];
   srs_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[ctl.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/srs_compare.sv */
// shared order compare: is the incoming record ahead of a stored one
// depends on srs_pkg; the incoming record always has the higher arrival number
module srs_compare (
   input  srs_pkg::entry_type cand,
   input  srs_pkg::entry_type held,
   output logic               ahead
);

   logic left_lt;
   logic left_eq;
   logic right_gt;
   logic right_eq;

   assign left_lt  = cand.left < held.left;
   assign left_eq  = cand.left == held.left;
   assign right_gt = cand.right > held.right;
   assign right_eq = cand.right == held.right;

   // equal span: single token keeps arrival order, multi token reverses it
   assign ahead = left_lt || (left_eq && right_gt) ||
                  (left_eq && right_eq && (cand.left != cand.right));

endmodule

/* design/span_record_sorter.sv */
// span record sorter: collects span records and emits them in sorted order
// depends on srs_pkg, srs_store, srs_compare, assert_macros.svh
//
// req channel takes one record word (left, right, final flag) when
// req_valid and req_ready are high; rsp channel gives sorted words.
// Each record is placed in order as it arrives by insertion: the shared
// comparator walks the store downward, reading (ST_SCAN) and comparing
// (ST_CMP) each stored record passed and shifting it up a slot.
// A record arriving while 64 are stored is dropped and flags the set.
// On a final record, all stored words follow in order, each by a store
// read, an output register load and a handoff; a stalled receiver simply
// holds rsp_valid and the word. req_ready is low from acceptance until the
// record is placed or dropped or, for a final record, until the last word
// of the run is taken.
// Reset (synchronous, active high) empties the set and clears the flag;
// store contents are not cleared, only entries below the count are read.
`include "assert_macros.svh"

module span_record_sorter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  srs_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output srs_pkg::rsp_word_type rsp_data
);

   srs_pkg::state_type    state_ff, state_in;
   logic [srs_pkg::CNT_W-1:0] count_ff, count_in;
   logic                  overflow_ff, overflow_in;
   logic                  final_ff, final_in;
   logic [srs_pkg::IDX_W-1:0] pos_ff, pos_in;
   srs_pkg::entry_type    cand_ff, cand_in;
   srs_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   srs_pkg::store_ctl_type ctl;
   srs_pkg::entry_type    rd_data;
   logic                  ahead;
   logic [srs_pkg::POS_WIDTH-1:0] clamp_left;
   logic                  last_word;
   logic                  at_full;

   srs_store u_store (
      .clock   (clock),
      .ctl     (ctl),
      .rd_data (rd_data)
   );

   srs_compare u_compare (
      .cand  (cand_ff),
      .held  (rd_data),
      .ahead (ahead)
   );

   assign clamp_left = (req_data.left_pos > req_data.right_pos) ?
                       req_data.right_pos : req_data.left_pos;
   assign last_word  = ({1'b0, pos_ff} + 7'd1) == count_ff;
   assign at_full    = count_ff == 7'(srs_pkg::MAX_RECORDS);

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srs_pkg::ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      final_ff <= final_in;
      pos_ff   <= pos_in;
      cand_ff  <= cand_in;
      rsp_ff   <= rsp_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      final_in     = final_ff;
      pos_in       = pos_ff;
      cand_in      = cand_ff;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      ctl.we       = 1'b0;
      ctl.waddr    = pos_ff;
      ctl.wdata    = cand_ff;
      ctl.raddr    = pos_ff;
      case (state_ff)
         srs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               final_in      = req_data.final_record;
               cand_in.left  = clamp_left;
               cand_in.right = req_data.right_pos;
               cand_in.order = count_ff[srs_pkg::IDX_W-1:0];
               pos_in        = count_ff[srs_pkg::IDX_W-1:0];
               if (at_full) begin
                  overflow_in = 1'b1;
                  state_in    = srs_pkg::ST_CHECK;
               end else begin
                  state_in = srs_pkg::ST_SCAN;
               end
            end
         end
         // issue read of the neighbor below, or place at the bottom
         srs_pkg::ST_SCAN: begin
            ctl.raddr = pos_ff - 6'd1;
            if (pos_ff == '0) begin
               ctl.we   = 1'b1;
               count_in = count_ff + 7'd1;
               state_in = srs_pkg::ST_CHECK;
            end else begin
               state_in = srs_pkg::ST_CMP;
            end
         end
         // shift the neighbor up or place the record here
         srs_pkg::ST_CMP: begin
            ctl.we = 1'b1;
            if (ahead) begin
               ctl.wdata = rd_data;
               pos_in    = pos_ff - 6'd1;
               state_in  = srs_pkg::ST_SCAN;
            end else begin
               count_in = count_ff + 7'd1;
               state_in = srs_pkg::ST_CHECK;
            end
         end
         srs_pkg::ST_CHECK: begin
            pos_in = '0;
            if (!final_ff) begin
               state_in = srs_pkg::ST_IDLE;
            end else if (count_ff == '0) begin
               overflow_in = 1'b0;
               state_in    = srs_pkg::ST_IDLE;
            end else begin
               state_in = srs_pkg::ST_FETCH;
            end
         end
         srs_pkg::ST_FETCH: begin
            state_in = srs_pkg::ST_LOAD;
         end
         srs_pkg::ST_LOAD: begin
            rsp_in.record_number = rd_data.order;
            rsp_in.out_left      = rd_data.left;
            rsp_in.out_right     = rd_data.right;
            rsp_in.out_last      = last_word;
            rsp_in.dropped       = overflow_ff;
            rsp_valid_in         = 1'b1;
            state_in             = srs_pkg::ST_SEND;
         end
         srs_pkg::ST_SEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               pos_in       = pos_ff + 6'd1;
               if (last_word) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = srs_pkg::ST_IDLE;
               end else begin
                  state_in = srs_pkg::ST_FETCH;
               end
            end
         end
         default: begin
            state_in = srs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `SRS_ASSERT(a_count_max, count_ff <= 7'(srs_pkg::MAX_RECORDS), "count beyond store")
   `SRS_ASSERT(a_no_overlap, !(req_ready && rsp_valid), "input open while a word is pending")
   `SRS_ASSERT(a_valid_state, rsp_valid |-> (state_ff == srs_pkg::ST_SEND), "word valid outside send")
   `SRS_ASSERT_NEXT(a_drop_full, !overflow_ff, !overflow_ff || $past(at_full), "drop with room left")

endmodule
